>>> sv/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class block allocator
// Command and status codes, the decoded request and result formats and the
// configuration register map.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Field widths of the request and result ports.
  localparam int CMD_W   = 2;
  localparam int SIZE_W  = 16;
  localparam int CLS_W   = 3;
  localparam int FIDX_W  = 4;
  localparam int STAT_W  = 3;

  // Configuration register map: one block count per size class.
  localparam int CFG_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] =
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd0};

  // Command codes on the request port.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2
  } cmd_t;

  // Status codes on the result port.
  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_FREED   = 3'd3,
    ST_BAD     = 3'd4,
    ST_REINIT  = 3'd5
  } status_t;

  // Operation kinds after classification by the front end.
  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_REINIT = 3'd2,
    OP_NOFIT  = 3'd3,
    OP_BAD    = 3'd4
  } op_kind_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    op_kind_t           kind;
    logic [CLS_W-1:0]   cls;
    logic [FIDX_W-1:0]  idx;
  } op_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [CLS_W-1:0]   gclass;
    logic [FIDX_W-1:0]  gindex;
  } res_t;

endpackage

>>> sv/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator: segregated fixed-size block pool allocator
// Allocates and frees fixed-size blocks in up to six power-of-two size
// classes, with a per-class block count set through the configuration port.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   push / full          in_command, in_request_size,
//                                 in_free_class, in_free_index
//  result    empty / pop          out_status, out_granted_class,
//                                 out_granted_index
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle while full is low. It is written into the
// operation queue, passes through the back end into the result queue and
// then shows on the result ports, where it can be popped.
// Reset is synchronous and active low; it clears the queues, sets every free
// mark and loads the default block counts. Either side may stall on its own:
// the two-entry queues absorb the difference until full is raised.
// ----------------------------------------------------------------------------
module size_class_block_allocator
  import scba_pkg::*;
#(
  parameter int MAX_BLOCKS     = 16,
  parameter int NUM_CLASSES    = 6,
  parameter int SMALLEST_BLOCK = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [CLS_W-1:0]     in_free_class,
  input  logic [FIDX_W-1:0]    in_free_index,
  output logic                 empty,
  input  logic                 pop,
  output logic [STAT_W-1:0]    out_status,
  output logic [CLS_W-1:0]     out_granted_class,
  output logic [FIDX_W-1:0]    out_granted_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cls_blocks_r [CFG_REGS];
  logic [CNT_W-1:0] blk_cnt [NUM_CLASSES];
  logic [CMP_W-1:0] cnt_wide [NUM_CLASSES];

  op_t  op_in, op_head;
  logic op_full, op_empty, op_take;
  res_t res_in, res_head;
  logic res_full, res_push;

  // Configuration registers: writes are always taken, unknown indexes ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < CFG_REGS; r++) begin
        cls_blocks_r[r] <= CFG_RESET[r];
      end
    end else if (cfg_valid) begin
      for (int r = 0; r < CFG_REGS; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) begin
          cls_blocks_r[r] <= cfg_data;
        end
      end
    end
  end

  // Effective block count per class, saturated at the pool size.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cnt_wide[c] = '0;
      if (c < CFG_REGS) begin
        if (CMP_W'(cls_blocks_r[c]) > CMP_W'(MAX_BLOCKS)) begin
          cnt_wide[c] = CMP_W'(MAX_BLOCKS);
        end else begin
          cnt_wide[c] = CMP_W'(cls_blocks_r[c]);
        end
      end
      blk_cnt[c] = cnt_wide[c][CNT_W-1:0];
    end
  end

  // Front end: classify the incoming request.
  scba_front #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .NUM_CLASSES    (NUM_CLASSES),
    .SMALLEST_BLOCK (SMALLEST_BLOCK),
    .CNT_W          (CNT_W)
  ) u_front (
    .command      (in_command),
    .request_size (in_request_size),
    .free_class   (in_free_class),
    .free_index   (in_free_index),
    .blk_cnt      (blk_cnt),
    .op           (op_in)
  );

  // Operation queue between front and back end.
  scba_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (2)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_take),
    .rdata (op_head),
    .empty (op_empty)
  );

  assign full = op_full;

  // Back end: free map and allocation.
  scba_back #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .NUM_CLASSES (NUM_CLASSES),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_head),
    .op_valid (!op_empty),
    .op_take  (op_take),
    .blk_cnt  (blk_cnt),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue towards the consumer.
  scba_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_status        = res_head.status;
  assign out_granted_class = res_head.gclass;
  assign out_granted_index = res_head.gindex;

  // A granted block always belongs to an existing class.
  a_grant_class: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_GRANTED) |-> (int'(out_granted_class) < NUM_CLASSES))
    else $error("granted class outside the configured classes");

  // Results other than a grant carry a zero handle.
  a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_GRANTED) |->
      (out_granted_class == '0 && out_granted_index == '0))
    else $error("non-grant result carries a handle");

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

>>> sv/scba_fifo.sv
// ----------------------------------------------------------------------------
// scba_fifo: small register queue
// A shallow first-in first-out queue with full and empty flags; a push and a
// pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module scba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> sv/scba_front.sv
// ----------------------------------------------------------------------------
// scba_front: request classifier
// Picks the size class of an allocate, checks the handle of a free and turns
// each request into a classified operation for the back end.
// ----------------------------------------------------------------------------
module scba_front
  import scba_pkg::*;
#(
  parameter int MAX_BLOCKS     = 16,
  parameter int NUM_CLASSES    = 6,
  parameter int SMALLEST_BLOCK = 32,
  parameter int CNT_W          = $clog2(MAX_BLOCKS + 1)
) (
  input  logic [CMD_W-1:0]  command,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [CLS_W-1:0]  free_class,
  input  logic [FIDX_W-1:0] free_index,
  input  logic [CNT_W-1:0]  blk_cnt [NUM_CLASSES],
  output op_t               op
);

  logic             fits;
  logic [CLS_W-1:0] fit_cls;
  logic             handle_ok;

  // Smallest class whose block size covers the request.
  always_comb begin
    fits    = 1'b0;
    fit_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (32'(request_size) <= (32'(SMALLEST_BLOCK) << c)) begin
        fits    = 1'b1;
        fit_cls = CLS_W'(c);
      end
    end
  end

  // A handle is good when its class exists and its index is below the count.
  always_comb begin
    handle_ok = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (free_class == CLS_W'(c) && int'(free_index) < int'(blk_cnt[c])) begin
        handle_ok = 1'b1;
      end
    end
  end

  // Classified operation.
  always_comb begin
    op.cls  = '0;
    op.idx  = '0;
    op.kind = OP_BAD;
    case (cmd_t'(command))
      CMD_ALLOC: begin
        op.kind = fits ? OP_ALLOC : OP_NOFIT;
        op.cls  = fit_cls;
      end
      CMD_FREE: begin
        op.kind = handle_ok ? OP_FREE : OP_BAD;
        op.cls  = free_class;
        op.idx  = free_index;
      end
      CMD_REINIT: begin
        op.kind = OP_REINIT;
      end
      default: begin
        op.kind = OP_BAD;
      end
    endcase
  end

endmodule

>>> sv/scba_back.sv
// ----------------------------------------------------------------------------
// scba_back: free map and allocation engine
// Holds the free marks of every class and carries out one classified
// operation per cycle while the result queue is not full, producing its result.
// ----------------------------------------------------------------------------
module scba_back
  import scba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 16,
  parameter int NUM_CLASSES = 6,
  parameter int CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  op_t              op,
  input  logic             op_valid,
  output logic             op_take,
  input  logic [CNT_W-1:0] blk_cnt [NUM_CLASSES],
  input  logic             res_full,
  output logic             res_push,
  output res_t             res
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [MAX_BLOCKS-1:0] marks_r   [NUM_CLASSES];
  logic [MAX_BLOCKS-1:0] marks_nxt [NUM_CLASSES];
  logic [MAX_BLOCKS-1:0] row;
  logic [CNT_W-1:0]      cnt;
  logic                  found;
  logic [IDX_W-1:0]      hit;
  logic [IDX_W+FIDX_W-1:0] hit_ext;

  assign op_take  = op_valid && !res_full;
  assign res_push = op_take;
  assign hit_ext  = {{FIDX_W{1'b0}}, hit};

  // Free marks and block count of the selected class.
  always_comb begin
    row = '0;
    cnt = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (op.cls == CLS_W'(c)) begin
        row = marks_r[c];
        cnt = blk_cnt[c];
      end
    end
  end

  // Lowest free block below the class's count.
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (row[i] && i < int'(cnt)) begin
        found = 1'b1;
        hit   = IDX_W'(i);
      end
    end
  end

  // Result and next free map.
  always_comb begin
    marks_nxt  = marks_r;
    res.status = ST_BAD;
    res.gclass = '0;
    res.gindex = '0;
    case (op.kind)
      OP_ALLOC: begin
        if (found) begin
          res.status = ST_GRANTED;
          res.gclass = op.cls;
          res.gindex = hit_ext[FIDX_W-1:0];
          for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
              if (op.cls == CLS_W'(c) && hit == IDX_W'(i)) begin
                marks_nxt[c][i] = 1'b0;
              end
            end
          end
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_FREE: begin
        res.status = ST_FREED;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (op.cls == CLS_W'(c) && int'(op.idx) == i) begin
              marks_nxt[c][i] = 1'b1;
            end
          end
        end
      end
      OP_REINIT: begin
        res.status = ST_REINIT;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          marks_nxt[c] = '1;
        end
      end
      OP_NOFIT: begin
        res.status = ST_NOFIT;
      end
      default: begin
        res.status = ST_BAD;
      end
    endcase
  end

  // Free map: every block free after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        marks_r[c] <= '1;
      end
    end else if (op_take) begin
      marks_r <= marks_nxt;
    end
  end

endmodule
